// ===== design/fraub_pkg.sv =====
// Shared constants, command codes and helpers for the register ALU and branch unit.
package fraub_pkg;

   localparam int REG_COUNT = 4;
   localparam int IDX_W     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   localparam int DATA_W    = 16;
   localparam int LINE_W    = 16;
   localparam int SEL_W     = 2;
   localparam int ITER_N    = DATA_W;
   localparam int CNT_W     = $clog2(ITER_N);
   localparam int ALU_W     = DATA_W + 2;
   localparam int REQ_W     = 56;
   localparam int RSP_W     = 40;
   localparam int CMD_W     = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_MOV   = 4'd0,
      CMD_ADD   = 4'd1,
      CMD_SUB   = 4'd2,
      CMD_MUL   = 4'd3,
      CMD_DIV   = 4'd4,
      CMD_READ  = 4'd5,
      CMD_PRINT = 4'd6,
      CMD_JMP   = 4'd7,
      CMD_JE    = 4'd8,
      CMD_JNE   = 4'd9,
      CMD_JG    = 4'd10,
      CMD_JGE   = 4'd11,
      CMD_JL    = 4'd12,
      CMD_JLE   = 4'd13
   } cmd_type;

   // Select field wraps into the register file; field is below twice the depth.
   function automatic logic [IDX_W-1:0] reg_index(input logic [SEL_W-1:0] sel);
      logic [SEL_W:0] wide;
      logic [SEL_W:0] depth;
      begin
         wide  = {1'b0, sel};
         depth = (SEL_W + 1)'(REG_COUNT);
         if (wide >= depth) begin
            wide = wide - depth;
         end
         reg_index = wide[IDX_W-1:0];
      end
   endfunction

   function automatic logic [ALU_W-1:0] sext(input logic [DATA_W-1:0] v);
      sext = {{(ALU_W-DATA_W){v[DATA_W-1]}}, v};
   endfunction

   function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
      magnitude = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
   endfunction

endpackage

// ===== design/four_register_alu_branch_unit_top.sv =====
// Register ALU and branch-compare unit: sequencer around one shared adder.
// Sequence: an accepted beat passes READ, EXEC and DONE for mov/add/sub/read/print/jumps and
// zero-divisor div; mul and div also pass ITER (16 shift-add or restore steps on the shared
// 18-bit adder) and FIX. A new beat is taken once the sequencer is back in idle, while the
// previous result may still sit in the output register.
// Reset: synchronous active high; clears control state and marks all registers as zero.
module four_register_alu_branch_unit_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // first_is_imm, first_reg[1:0], first_imm[15:0], second_is_imm, second_reg[1:0],
   // second_imm[15:0], target_line[15:0], zero fill
   input  logic [fraub_pkg::REQ_W-1:0] req_tdata,
   // command[3:0]
   input  logic [fraub_pkg::CMD_W-1:0] req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // jump_taken, jump_line[15:0], print_valid, print_value[15:0], divide_by_zero, zero fill
   output logic [fraub_pkg::RSP_W-1:0] rsp_tdata
);

   localparam int DW = fraub_pkg::DATA_W;
   localparam int AW = fraub_pkg::ALU_W;
   localparam int IW = fraub_pkg::IDX_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_ITER,
      ST_FIX,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   fraub_pkg::cmd_type         cmd_ff;
   logic                       f_imm_ff;
   logic [IW-1:0]              f_idx_ff;
   logic [DW-1:0]              f_val_ff;
   logic                       s_imm_ff;
   logic [IW-1:0]              s_idx_ff;
   logic [DW-1:0]              s_val_ff;
   logic [fraub_pkg::LINE_W-1:0] target_ff;

   logic [DW-1:0] rd_a_ff, rd_b_ff;
   logic [DW-1:0] acc_ff, opx_ff, opy_ff;
   logic [fraub_pkg::CNT_W-1:0] cnt_ff;
   logic          neg_ff;

   logic          taken_ff, pvalid_ff, dz_ff;
   logic [DW-1:0] pvalue_ff;

   logic          rsp_valid_ff;
   logic [fraub_pkg::RSP_W-1:0] rsp_data_ff;

   logic [DW-1:0] regs_mem [fraub_pkg::REG_COUNT];
   logic [fraub_pkg::REG_COUNT-1:0] valid_ff;

   logic          wr_en;
   logic [DW-1:0] wr_data;

   logic [AW-1:0] op_a, op_b, sum;
   logic          op_sub;

   logic [DW-1:0] src, dst, cmp_y;
   logic [DW:0]   rem_shift;
   logic          cmp_lt, cmp_eq, cond;
   logic          req_fire, rsp_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign src       = f_imm_ff ? f_val_ff : rd_a_ff;
   assign dst       = rd_b_ff;
   assign cmp_y     = s_imm_ff ? s_val_ff : rd_b_ff;
   assign rem_shift = {acc_ff, opx_ff[DW-1]};

   // shared adder
   always_comb begin
      op_a   = '0;
      op_b   = '0;
      op_sub = 1'b0;
      case (state_ff)
         ST_EXEC: begin
            case (cmd_ff)
               fraub_pkg::CMD_ADD: begin
                  op_a = fraub_pkg::sext(src);
                  op_b = fraub_pkg::sext(dst);
               end
               fraub_pkg::CMD_SUB: begin
                  op_a   = fraub_pkg::sext(dst);
                  op_b   = fraub_pkg::sext(src);
                  op_sub = 1'b1;
               end
               default: begin
                  op_a   = fraub_pkg::sext(src);
                  op_b   = fraub_pkg::sext(cmp_y);
                  op_sub = 1'b1;
               end
            endcase
         end
         ST_ITER: begin
            if (cmd_ff == fraub_pkg::CMD_MUL) begin
               op_a = {2'b00, acc_ff};
               op_b = opy_ff[0] ? {2'b00, opx_ff} : '0;
            end else begin
               op_a   = {1'b0, rem_shift};
               op_b   = {2'b00, opy_ff};
               op_sub = 1'b1;
            end
         end
         ST_FIX: begin
            op_a   = '0;
            op_b   = {2'b00, opx_ff};
            op_sub = 1'b1;
         end
         default: begin
            op_a   = '0;
            op_b   = '0;
            op_sub = 1'b0;
         end
      endcase
   end

   assign sum    = op_a + (op_b ^ {AW{op_sub}}) + AW'(op_sub);
   assign cmp_lt = sum[AW-1];
   assign cmp_eq = (sum == '0);

   always_comb begin
      case (cmd_ff)
         fraub_pkg::CMD_JMP: cond = 1'b1;
         fraub_pkg::CMD_JE:  cond = cmp_eq;
         fraub_pkg::CMD_JNE: cond = !cmp_eq;
         fraub_pkg::CMD_JG:  cond = !cmp_lt && !cmp_eq;
         fraub_pkg::CMD_JGE: cond = !cmp_lt;
         fraub_pkg::CMD_JL:  cond = cmp_lt;
         fraub_pkg::CMD_JLE: cond = cmp_lt || cmp_eq;
         default:            cond = 1'b0;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_data = sum[DW-1:0];
      if (state_ff == ST_EXEC) begin
         case (cmd_ff)
            fraub_pkg::CMD_MOV: begin
               wr_en   = 1'b1;
               wr_data = src;
            end
            fraub_pkg::CMD_READ: begin
               wr_en   = 1'b1;
               wr_data = f_val_ff;
            end
            fraub_pkg::CMD_ADD, fraub_pkg::CMD_SUB: wr_en = 1'b1;
            default: wr_en = 1'b0;
         endcase
      end else if (state_ff == ST_FIX) begin
         wr_en = 1'b1;
         if (cmd_ff == fraub_pkg::CMD_MUL) begin
            wr_data = acc_ff;
         end else if (neg_ff) begin
            wr_data = sum[DW-1:0];
         end else begin
            wr_data = opx_ff;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_fire) state_in = ST_READ;
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: begin
            if (cmd_ff == fraub_pkg::CMD_MUL ||
                (cmd_ff == fraub_pkg::CMD_DIV && dst != '0)) begin
               state_in = ST_ITER;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_ITER: if (cnt_ff == fraub_pkg::CNT_W'(fraub_pkg::ITER_N - 1)) state_in = ST_FIX;
         ST_FIX:  state_in = ST_DONE;
         ST_DONE: if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // register file, entries read as zero until first written
   always_ff @(posedge clock) begin
      if (wr_en) begin
         regs_mem[s_idx_ff] <= wr_data;
      end
      if (state_ff == ST_READ) begin
         rd_a_ff <= valid_ff[f_idx_ff] ? regs_mem[f_idx_ff] : '0;
         rd_b_ff <= valid_ff[s_idx_ff] ? regs_mem[s_idx_ff] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[s_idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (req_fire) begin
         cmd_ff    <= fraub_pkg::cmd_type'(req_tuser);
         f_imm_ff  <= req_tdata[0];
         f_idx_ff  <= fraub_pkg::reg_index(req_tdata[2:1]);
         f_val_ff  <= req_tdata[18:3];
         s_imm_ff  <= req_tdata[19];
         s_idx_ff  <= fraub_pkg::reg_index(req_tdata[21:20]);
         s_val_ff  <= req_tdata[37:22];
         target_ff <= req_tdata[53:38];
      end

      case (state_ff)
         ST_EXEC: begin
            taken_ff  <= cond && (target_ff != '0);
            pvalid_ff <= (cmd_ff == fraub_pkg::CMD_PRINT);
            pvalue_ff <= (cmd_ff == fraub_pkg::CMD_PRINT) ? rd_a_ff : '0;
            dz_ff     <= (cmd_ff == fraub_pkg::CMD_DIV) && (dst == '0);
            cnt_ff    <= '0;
            acc_ff    <= '0;
            if (cmd_ff == fraub_pkg::CMD_MUL) begin
               opx_ff <= src;
               opy_ff <= dst;
               neg_ff <= 1'b0;
            end else begin
               opx_ff <= fraub_pkg::magnitude(src);
               opy_ff <= fraub_pkg::magnitude(dst);
               neg_ff <= src[DW-1] ^ dst[DW-1];
            end
         end
         ST_ITER: begin
            cnt_ff <= cnt_ff + fraub_pkg::CNT_W'(1);
            if (cmd_ff == fraub_pkg::CMD_MUL) begin
               acc_ff <= sum[DW-1:0];
               opx_ff <= {opx_ff[DW-2:0], 1'b0};
               opy_ff <= {1'b0, opy_ff[DW-1:1]};
            end else begin
               acc_ff <= sum[AW-1] ? rem_shift[DW-1:0] : sum[DW-1:0];
               opx_ff <= {opx_ff[DW-2:0], !sum[AW-1]};
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_data_ff <= {5'd0, dz_ff, pvalue_ff, pvalid_ff,
                               taken_ff ? target_ff : 16'd0, taken_ff};
            end
         end
         default: begin
         end
      endcase
   end

endmodule
